/* src/pea_pkg.sv */
// Shared types, codes and defaults for the page extent allocator.
package pea_pkg;

  localparam int MAX_EXTENTS_DEF     = 64;
  localparam int PAGE_INDEX_BITS_DEF = 32;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_COUNT  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_FROM_UP,
    ACT_FROM_DOWN,
    ACT_LOAD,
    ACT_CARVE,
    ACT_GROW,
    ACT_JOIN,
    ACT_REBASE
  } act_t;

  typedef struct packed {
    logic vld;
    logic fit;
    logic zero;
    logic le;
    logic end_eq;
    logic beg_eq;
  } flags_t;

endpackage

/* src/pea_cell.sv */
// One table slot: holds an extent, compares it against the word, and updates or shifts.
module pea_cell #(
  parameter int PAGE_INDEX_BITS = pea_pkg::PAGE_INDEX_BITS_DEF,
  parameter int AW = ((PAGE_INDEX_BITS > 32) ? PAGE_INDEX_BITS : 32) + 1
) (
  input  logic                       clk,
  input  logic                       eval,
  input  logic                       go,
  input  logic                       valid,
  input  pea_pkg::act_t              act,
  input  logic [PAGE_INDEX_BITS-1:0] idx,
  input  logic [AW-1:0]              cnt,
  input  logic [AW-1:0]              sum,
  input  logic [PAGE_INDEX_BITS-1:0] up_start,
  input  logic [PAGE_INDEX_BITS:0]   up_len,
  input  logic [PAGE_INDEX_BITS-1:0] dn_start,
  input  logic [PAGE_INDEX_BITS:0]   dn_len,
  output logic [PAGE_INDEX_BITS-1:0] start,
  output logic [PAGE_INDEX_BITS:0]   len,
  output logic [PAGE_INDEX_BITS:0]   page,
  output pea_pkg::flags_t            flags
);

  localparam int SW = PAGE_INDEX_BITS;
  localparam int LW = PAGE_INDEX_BITS + 1;

  logic [SW-1:0]   start_r, start_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   rem_r;
  pea_pkg::flags_t flags_r, flags_nxt;
  logic [LW-1:0]   cnt_l;
  logic [LW-1:0]   end_pg;

  assign cnt_l  = cnt[LW-1:0];
  assign end_pg = LW'(start_r) + len_r;

  always_comb begin
    flags_nxt.vld    = valid;
    flags_nxt.fit    = valid && (AW'(len_r) >= cnt);
    flags_nxt.zero   = (AW'(len_r) == cnt);
    flags_nxt.le     = valid && (start_r <= idx);
    flags_nxt.end_eq = (end_pg == LW'(idx));
    flags_nxt.beg_eq = (sum == AW'(start_r));
  end

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    case (act)
      pea_pkg::ACT_HOLD: begin
      end
      pea_pkg::ACT_FROM_UP: begin
        start_nxt = up_start;
        len_nxt   = up_len;
      end
      pea_pkg::ACT_FROM_DOWN: begin
        start_nxt = dn_start;
        len_nxt   = dn_len;
      end
      pea_pkg::ACT_LOAD: begin
        start_nxt = idx;
        len_nxt   = cnt_l;
      end
      pea_pkg::ACT_CARVE: begin
        len_nxt = rem_r;
      end
      pea_pkg::ACT_GROW: begin
        len_nxt = len_r + cnt_l;
      end
      pea_pkg::ACT_JOIN: begin
        len_nxt = len_r + cnt_l + up_len;
      end
      pea_pkg::ACT_REBASE: begin
        start_nxt = idx;
        len_nxt   = len_r + cnt_l;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      flags_r <= flags_nxt;
      rem_r   <= len_r - cnt_l;
    end
    if (go) begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  // carve from the top end: the run begins where the remainder ends
  assign page  = LW'(start_r) + rem_r;
  assign start = start_r;
  assign len   = len_r;
  assign flags = flags_r;

endmodule

/* src/page_extent_allocator.sv */
// Top level: first-fit page allocator (searching from the highest extent down) over a chain of extent cells.
//
//   channel | ports                                   | direction
//   in      | in_valid, in_stall, in_cmd,             | request word in
//           | in_page_index, in_page_count            |
//   out     | out_valid, out_stall, out_status,       | result word out
//           | out_alloc_page                          |
//
// Each word passes through capture, parallel compare in every cell, then
// apply (update, shift up or shift down by one slot across the chain).
// A new word is taken once the previous one leaves apply; apply waits while
// the result register still holds an untaken word.
// Reset empties the table at once (fill count only); slot contents are
// undefined until written.
module page_extent_allocator #(
  parameter int MAX_EXTENTS     = pea_pkg::MAX_EXTENTS_DEF,
  parameter int PAGE_INDEX_BITS = pea_pkg::PAGE_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_page_index,
  input  logic [31:0] in_page_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_page
);

  localparam int SW = PAGE_INDEX_BITS;
  localparam int LW = PAGE_INDEX_BITS + 1;
  localparam int AW = ((PAGE_INDEX_BITS > 32) ? PAGE_INDEX_BITS : 32) + 1;
  localparam int UW = $clog2(MAX_EXTENTS + 1);

  pea_pkg::state_t state_r, state_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic            cmd_r;
  logic [SW-1:0]   idx_r;
  logic [AW-1:0]   cnt_r, sum_r;
  logic            bad_r;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, status_nxt;
  logic [31:0]     out_page_r;

  logic            in_acc, eval, go;
  logic [AW-1:0]   in_idx_w, in_cnt_w, in_sum_w;
  logic            in_bad;

  pea_pkg::flags_t flg [MAX_EXTENTS];
  logic [SW-1:0]   st_q [MAX_EXTENTS];
  logic [LW-1:0]   ln_q [MAX_EXTENTS];
  logic [LW-1:0]   pg_q [MAX_EXTENTS];
  pea_pkg::act_t   act  [MAX_EXTENTS];

  logic [MAX_EXTENTS:0]   hi_or;
  logic [MAX_EXTENTS-1:0] hit;
  logic [MAX_EXTENTS-1:0] sd;
  logic [MAX_EXTENTS-1:0] lower, upper, ins;
  logic [MAX_EXTENTS-1:0] lo_v, hi_v;
  logic [LW-1:0]          pg_or [MAX_EXTENTS+1];

  logic found, drop, merge_lo, merge_hi, full;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != pea_pkg::S_IDLE);
  assign eval     = (state_r == pea_pkg::S_EVAL);
  assign go       = (state_r == pea_pkg::S_APPLY) && (!out_valid_r || !out_stall);

  assign in_idx_w = AW'(in_page_index);
  assign in_cnt_w = AW'(in_page_count);
  assign in_sum_w = in_idx_w + in_cnt_w;
  // a free must fit in page space; either command rejects a zero count
  assign in_bad   = (in_page_count == 32'd0) ||
                    ((in_cmd == pea_pkg::CMD_FREE) && (in_sum_w > (AW'(1) << SW)));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_cmd;
      idx_r <= in_idx_w[SW-1:0];
      cnt_r <= in_cnt_w;
      sum_r <= in_sum_w;
      bad_r <= in_bad;
    end
  end

  // neighbor chains: priority from the top, shift-down from the drop point
  assign hi_or[MAX_EXTENTS]   = 1'b0;
  assign pg_or[MAX_EXTENTS]   = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_EXTENTS; k++) begin : g_cell
      logic          valid_k;
      logic [SW-1:0] up_s, dn_s;
      logic [LW-1:0] up_l, dn_l;
      logic          le_up, le_dn;

      assign valid_k = (UW'(k) < used_r);
      assign hi_or[k] = flg[k].fit | hi_or[k+1];
      assign hit[k]   = flg[k].fit & !hi_or[k+1];
      assign pg_or[k] = pg_or[k+1] | (hit[k] ? pg_q[k] : '0);

      if (k == MAX_EXTENTS - 1) begin : g_top
        assign up_s  = '0;
        assign up_l  = '0;
        assign le_up = 1'b0;
      end else begin : g_mid
        assign up_s  = st_q[k+1];
        assign up_l  = ln_q[k+1];
        assign le_up = flg[k+1].le;
      end

      if (k == 0) begin : g_bot
        assign dn_s  = '0;
        assign dn_l  = '0;
        assign le_dn = 1'b1;
        assign sd[k] = hit[k] & flg[k].zero;
      end else begin : g_hi
        assign dn_s  = st_q[k-1];
        assign dn_l  = ln_q[k-1];
        assign le_dn = flg[k-1].le;
        assign sd[k] = sd[k-1] | (hit[k] & flg[k].zero);
      end

      assign lower[k] = flg[k].le & !le_up;
      assign upper[k] = flg[k].vld & !flg[k].le & le_dn;
      assign ins[k]   = !flg[k].le & le_dn;
      assign lo_v[k]  = lower[k] & flg[k].end_eq;
      assign hi_v[k]  = upper[k] & flg[k].beg_eq;

      always_comb begin
        act[k] = pea_pkg::ACT_HOLD;
        if (!bad_r) begin
          if (cmd_r == pea_pkg::CMD_ALLOC) begin
            if (sd[k]) begin
              act[k] = pea_pkg::ACT_FROM_UP;
            end else if (hit[k]) begin
              act[k] = pea_pkg::ACT_CARVE;
            end
          end else if (merge_lo && merge_hi) begin
            if (lower[k]) begin
              act[k] = pea_pkg::ACT_JOIN;
            end else if (!flg[k].le) begin
              act[k] = pea_pkg::ACT_FROM_UP;
            end
          end else if (merge_lo) begin
            if (lower[k]) begin
              act[k] = pea_pkg::ACT_GROW;
            end
          end else if (merge_hi) begin
            if (upper[k]) begin
              act[k] = pea_pkg::ACT_REBASE;
            end
          end else if (!full) begin
            if (ins[k]) begin
              act[k] = pea_pkg::ACT_LOAD;
            end else if (!le_dn) begin
              act[k] = pea_pkg::ACT_FROM_DOWN;
            end
          end
        end
      end

      pea_cell #(
        .PAGE_INDEX_BITS(PAGE_INDEX_BITS),
        .AW(AW)
      ) u_cell (
        .clk(clk),
        .eval(eval),
        .go(go),
        .valid(valid_k),
        .act(act[k]),
        .idx(idx_r),
        .cnt(cnt_r),
        .sum(sum_r),
        .up_start(up_s),
        .up_len(up_l),
        .dn_start(dn_s),
        .dn_len(dn_l),
        .start(st_q[k]),
        .len(ln_q[k]),
        .page(pg_q[k]),
        .flags(flg[k])
      );
    end
  endgenerate

  assign found    = hi_or[0];
  assign drop     = sd[MAX_EXTENTS-1];
  assign merge_lo = |lo_v;
  assign merge_hi = |hi_v;
  assign full     = (used_r == UW'(MAX_EXTENTS));

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    status_nxt    = pea_pkg::ST_OK;
    out_valid_nxt = out_valid_r && out_stall;
    if (bad_r) begin
      status_nxt = pea_pkg::ST_BAD_COUNT;
    end else if (cmd_r == pea_pkg::CMD_ALLOC) begin
      if (!found) begin
        status_nxt = pea_pkg::ST_NO_SPACE;
      end else if (drop) begin
        used_nxt = used_r - UW'(1);
      end
    end else if (merge_lo && merge_hi) begin
      used_nxt = used_r - UW'(1);
    end else if (!merge_lo && !merge_hi) begin
      if (full) begin
        status_nxt = pea_pkg::ST_TABLE_FULL;
      end else begin
        used_nxt = used_r + UW'(1);
      end
    end
    case (state_r)
      pea_pkg::S_IDLE: begin
        used_nxt = used_r;
        if (in_acc) begin
          state_nxt = pea_pkg::S_EVAL;
        end
      end
      pea_pkg::S_EVAL: begin
        used_nxt  = used_r;
        state_nxt = pea_pkg::S_APPLY;
      end
      pea_pkg::S_APPLY: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = pea_pkg::S_IDLE;
        end else begin
          used_nxt = used_r;
        end
      end
      default: begin
        used_nxt  = used_r;
        state_nxt = pea_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pea_pkg::S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= status_nxt;
      out_page_r   <= (status_nxt == pea_pkg::ST_OK && cmd_r == pea_pkg::CMD_ALLOC)
                      ? 32'(AW'(pg_or[0])) : 32'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_page = out_page_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(MAX_EXTENTS))
    else $error("extent count above table size");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == pea_pkg::S_EVAL)
    else $error("accepted word did not enter compare");

  a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("apply left no result word");

  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != pea_pkg::ST_OK) |-> out_page_r == 32'd0)
    else $error("failed request returned a page");

  a_used_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pea_pkg::S_IDLE) |=> $stable(used_r))
    else $error("extent count moved outside apply");

endmodule

/* bench/pea_checker.sv */
// Checker for the page extent allocator: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pea_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_page_index,
  input  logic [31:0] in_page_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_alloc_page,
  output int          fail_count,
  output int          pending
);

  localparam int NX = pea_pkg::MAX_EXTENTS_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page;
  } reply_t;

  logic [63:0] ext_base [NX];
  logic [63:0] ext_len  [NX];
  int          ext_cnt;
  reply_t      reply_q [$];

  function automatic void remove_at(int pos);
    for (int k = pos; k + 1 < ext_cnt; k++) begin
      ext_base[k] = ext_base[k+1];
      ext_len[k]  = ext_len[k+1];
    end
    ext_cnt--;
  endfunction

  function automatic reply_t take_pages(logic [63:0] cnt);
    reply_t r;
    r = '{pea_pkg::ST_NO_SPACE, 32'd0};
    if (cnt == 0) return '{pea_pkg::ST_BAD_COUNT, 32'd0};
    for (int i = ext_cnt - 1; i >= 0; i--) begin
      if (ext_len[i] >= cnt) begin
        ext_len[i] -= cnt;
        r = '{pea_pkg::ST_OK, 32'(ext_base[i] + ext_len[i])};
        if (ext_len[i] == 0) remove_at(i);
        return r;
      end
    end
    return r;
  endfunction

  function automatic reply_t return_pages(logic [63:0] idx, logic [63:0] cnt);
    int  up;
    bit  lo, hi;
    up = 0;
    if (cnt == 0 || idx + cnt > 64'h1_0000_0000) return '{pea_pkg::ST_BAD_COUNT, 32'd0};
    while (up < ext_cnt && ext_base[up] <= idx) up++;
    lo = up > 0 && ext_base[up-1] + ext_len[up-1] == idx;
    hi = up < ext_cnt && idx + cnt == ext_base[up];
    if (lo) begin
      ext_len[up-1] += cnt;
      if (hi) begin
        ext_len[up-1] += ext_len[up];
        remove_at(up);
      end
    end else if (hi) begin
      ext_base[up] = idx;
      ext_len[up] += cnt;
    end else begin
      if (ext_cnt >= NX) return '{pea_pkg::ST_TABLE_FULL, 32'd0};
      for (int k = ext_cnt; k > up; k--) begin
        ext_base[k] = ext_base[k-1];
        ext_len[k]  = ext_len[k-1];
      end
      ext_base[up] = idx;
      ext_len[up]  = cnt;
      ext_cnt++;
    end
    return '{pea_pkg::ST_OK, 32'd0};
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      ext_cnt = 0;
      reply_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected word status=%0d page=%h", $time, out_status,
                   out_alloc_page);
          fail_count <= fail_count + 1;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            fail_count <= fail_count + 1;
          end else if (out_alloc_page !== want.page) begin
            $display("%0t: alloc_page expected %h actual %h", $time, want.page,
                     out_alloc_page);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == pea_pkg::CMD_ALLOC) begin
          reply_q.push_back(take_pages({32'd0, in_page_count}));
        end else begin
          reply_q.push_back(return_pages({32'd0, in_page_index}, {32'd0, in_page_count}));
        end
      end
    end
    pending <= reply_q.size();
  end
endmodule

/* bench/tb_top.sv */
// Testbench top: stimulus, stalls and verdict for the page extent allocator.
`timescale 1ns / 1ps
module tb_top;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_stall, in_cmd = 0;
  logic [31:0] in_page_index = 0, in_page_count = 0;
  logic        out_valid, out_stall = 0;
  logic [1:0]  out_status;
  logic [31:0] out_alloc_page;
  int          fail_count, pending;
  bit          hold_rx = 0;

  always #10 clk = ~clk;

  page_extent_allocator DUT (.*);
  pea_checker u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send(logic c, logic [31:0] idx, logic [31:0] cnt);
    in_valid <= 1;
    in_cmd <= c;
    in_page_index <= idx;
    in_page_count <= cnt;
    // stall only moves at the rising edge, so its value here holds for the next edge
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_gap(logic c, logic [31:0] idx, logic [31:0] cnt);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    send(c, idx, cnt);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // random small runs in a window so frees and allocs hit neighbors often
  function automatic logic [31:0] small_cnt();
    return $urandom_range(0, 99) < 90 ? $urandom_range(1, 8) : $urandom();
  endfunction

  initial begin
    forever begin
      @(negedge clk);
      if (hold_rx) out_stall <= 1;
      else if ($urandom_range(0, 99) < 5) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
        out_stall <= hold_rx;
      end else out_stall <= $urandom_range(0, 99) < 20;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed
    send(pea_pkg::CMD_ALLOC, 0, 1);
    send(pea_pkg::CMD_FREE, 0, 0);
    send(pea_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 0);
    send(pea_pkg::CMD_FREE, 32'hFFFF_FFFF, 2);
    send(pea_pkg::CMD_FREE, 32'hFFFF_FFFF, 1);
    send(pea_pkg::CMD_FREE, 0, 32'hFFFF_FFFF);
    send(pea_pkg::CMD_ALLOC, 0, 32'hFFFF_FFFF);
    send(pea_pkg::CMD_ALLOC, 0, 32'hFFFF_FFFF);
    send(pea_pkg::CMD_FREE, 100, 10);
    send(pea_pkg::CMD_FREE, 110, 5);
    send(pea_pkg::CMD_FREE, 90, 10);
    send(pea_pkg::CMD_FREE, 200, 10);
    send(pea_pkg::CMD_FREE, 150, 50);
    send(pea_pkg::CMD_ALLOC, 0, 1000);
    send(pea_pkg::CMD_ALLOC, 0, 5);
    send(pea_pkg::CMD_ALLOC, 0, 115);
    send(pea_pkg::CMD_FREE, 100, 10);
    send(pea_pkg::CMD_FREE, 100, 10);
    drain();
    // fill the table, then overflow it
    for (int i = 0; i < 66; i++) send(pea_pkg::CMD_FREE, 1000 + 2 * i, 1);
    send(pea_pkg::CMD_FREE, 1001, 1);
    send(pea_pkg::CMD_ALLOC, 0, 2);
    // long receiver hold while input keeps coming
    hold_rx = 1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 20; i++) send(pea_pkg::CMD_ALLOC, 0, 1);
    join
    drain();
    // random
    for (int i = 0; i < 2000; i++) begin
      int r;
      logic [31:0] base;
      r = $urandom_range(0, 99);
      base = $urandom_range(0, 99) < 85 ? $urandom_range(0, 600) : $urandom();
      if (i == 1000) drain();
      if (r < 45) send_gap(pea_pkg::CMD_ALLOC, $urandom(), small_cnt());
      else if (r < 95) send_gap(pea_pkg::CMD_FREE, base, small_cnt());
      else send_gap(1'($urandom_range(0, 1)), $urandom(),
                    $urandom_range(0, 1) ? 32'd0 : $urandom());
    end
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

/* page_extent_allocator.f */
src/pea_pkg.sv
src/pea_cell.sv
src/page_extent_allocator.sv
bench/pea_checker.sv
bench/tb_top.sv
